// ----- rtl/lz4fsd_pkg.sv -----
// Types and constants shared by the LZ4 frame stream decompressor files.
package lz4fsd_pkg;

    typedef enum logic [14:0] {
        PH_MAGIC  = 15'h0001,
        PH_FLG    = 15'h0002,
        PH_BD     = 15'h0004,
        PH_CSIZE  = 15'h0008,
        PH_HC     = 15'h0010,
        PH_BSIZE  = 15'h0020,
        PH_STORED = 15'h0040,
        PH_BCHK   = 15'h0080,
        PH_FCHK   = 15'h0100,
        PH_TOKEN  = 15'h0200,
        PH_LITLEN = 15'h0400,
        PH_LITRUN = 15'h0800,
        PH_OFFLO  = 15'h1000,
        PH_OFFHI  = 15'h2000,
        PH_MATLEN = 15'h4000
    } phase_t;

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ERR_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_HEADER  = 3'd2;
    localparam logic [2:0] ERR_OFFSET  = 3'd3;
    localparam logic [2:0] ERR_OVERRUN = 3'd4;
    localparam logic [2:0] ERR_LENGTH  = 3'd5;
    localparam logic [2:0] ERR_COPYING = 3'd6;
    localparam logic [2:0] ST_ENDED    = 3'd7;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ENDED = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] REG_FRAME_MODE = 2'd0;
    localparam logic [1:0] REG_RAW_BYTES  = 2'd1;
    localparam logic [1:0] REG_FRAME_LIM  = 2'd2;

    localparam logic       REQ_BYTE = 1'b0;
    localparam logic       REQ_TICK = 1'b1;

    localparam logic [7:0] FLG_BCHK  = 8'h10;
    localparam logic [7:0] FLG_CSIZE = 8'h08;
    localparam logic [7:0] FLG_FCHK  = 8'h04;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        unique case (idx)
            2'd0: magic_byte = 8'h04;
            2'd1: magic_byte = 8'h22;
            2'd2: magic_byte = 8'h4d;
            default: magic_byte = 8'h18;
        endcase
    endfunction

endpackage

// ----- rtl/lz4_frame_stream_decompressor.sv -----
// LZ4 frame and raw block stream decompressor with a wrapping history window.
// Results are held in an output register and appear in the cycle after the request is accepted.
// Throughput: one request per cycle while the output register is free or being taken, with one
// window memory read per match tick; a tick whose source byte is still a pending write forwards it.
// Reset: synchronous, active low, restarting control state. A clearing pass then zeroes the
// whole window, during which no request is accepted.
module lz4_frame_stream_decompressor #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // kind[1:0], out_byte[9:2], block_last[10],
                                   // stream_last[11], copy_pending[12], error_code[15:13]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lz4fsd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    logic [7:0]    hist_mem [WINDOW_BYTES];
    logic [7:0]    rd_data_reg;
    logic          use_mem_reg;
    logic [7:0]    fwd_reg;

    logic          clearing_reg;
    logic [AW-1:0] clr_pos_reg;

    logic          mode_reg;
    logic [31:0]   raw_bytes_reg;
    logic [15:0]   flim_reg;

    phase_t        phase_reg, phase_next;
    logic [3:0]    fbi_reg, fbi_next;
    logic [15:0]   moff_reg, moff_next;
    logic [31:0]   mrem_reg, mrem_next;
    logic [31:0]   lrem_reg, lrem_next;
    logic [31:0]   bsize_reg, bsize_next;
    logic [31:0]   bcons_reg, bcons_next;
    logic [7:0]    flags_reg, flags_next;
    logic [15:0]   fdone_reg, fdone_next;
    logic [15:0]   fleft_reg, fleft_next;
    logic          mok_reg, mok_next;
    logic [2:0]    sticky_reg, sticky_next;
    logic [3:0]    nib_reg, nib_next;
    logic [AW-1:0] wpos_reg;

    // output register; data byte of a tick is resolved from memory or forwarding at output
    logic          ov_reg;
    logic [1:0]    okind_reg;
    logic [7:0]    obyte_reg;
    logic          oblast_reg, oslast_reg, ocp_reg;
    logic [2:0]    oerr_reg;
    logic          otick_reg;

    logic          hold_reg;
    logic [7:0]    tick_byte;

    // every byte write to the window lands in the cycle after its request; hold it here
    logic          pw_reg;
    logic          pw_tick_reg;
    logic [7:0]    pw_byte_reg;
    logic [AW-1:0] pw_addr_reg;
    logic [7:0]    pw_data;

    logic          in_acc;
    logic          tick_now;
    logic          wr_en;
    logic [7:0]    wr_byte;
    logic [AW-1:0] src_addr;
    logic [1:0]    kind_c;
    logic [7:0]    data_c;
    logic          blast_c, slast_c;
    logic [2:0]    err_c;
    logic          ended_c;
    logic          cp_c;
    logic          cfg_acc;
    logic [32:0]   sum33;

    assign s_tready  = !clearing_reg && (!ov_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // byte produced by the last tick, from memory or forwarded
    assign tick_byte = use_mem_reg ? rd_data_reg : fwd_reg;
    assign pw_data   = pw_tick_reg ? tick_byte : pw_byte_reg;

    assign src_addr = wpos_reg - AW'(moff_reg);

    always_comb begin
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        moff_next   = moff_reg;
        mrem_next   = mrem_reg;
        lrem_next   = lrem_reg;
        bsize_next  = bsize_reg;
        bcons_next  = bcons_reg;
        flags_next  = flags_reg;
        fdone_next  = fdone_reg;
        fleft_next  = fleft_reg;
        mok_next    = mok_reg;
        sticky_next = sticky_reg;
        nib_next    = nib_reg;
        kind_c      = KIND_NONE;
        data_c      = 8'd0;
        blast_c     = 1'b0;
        slast_c     = 1'b0;
        err_c       = ST_RUN;
        ended_c     = 1'b0;
        tick_now    = 1'b0;
        wr_en       = 1'b0;
        wr_byte     = s_tdata;
        sum33       = 33'd0;
        cp_c        = (sticky_reg == ST_RUN) && (phase_reg == PH_TOKEN) && (mrem_reg != 32'd0);
        if (sticky_reg == ST_ENDED) begin
            kind_c = KIND_ENDED;
        end else if (sticky_reg != ST_RUN) begin
            kind_c = KIND_ERROR;
        end else if (s_tuser == REQ_TICK) begin
            if (cp_c) begin
                tick_now  = 1'b1;
                wr_en     = 1'b1;
                mrem_next = mrem_reg - 32'd1;
                kind_c    = KIND_DATA;
            end
        end else if (cp_c) begin
            err_c = ERR_COPYING;
        end else if (phase_reg >= PH_TOKEN && bcons_reg >= bsize_reg) begin
            err_c = ERR_OVERRUN;
        end else begin
            if (phase_reg >= PH_TOKEN) bcons_next = bcons_reg + 32'd1;
            unique case (phase_reg)
                PH_MAGIC: begin
                    if (s_tdata != magic_byte(fbi_reg[1:0])) mok_next = 1'b0;
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_reg == 4'd3) begin
                        fbi_next = 4'd0;
                        if (mok_next) phase_next = PH_FLG;
                        else if (fdone_reg == 16'd0) err_c = ERR_MAGIC;
                        else begin
                            sticky_next = ST_ENDED;
                            ended_c     = 1'b1;
                        end
                    end
                end
                PH_FLG: begin
                    flags_next = s_tdata;
                    if (s_tdata[7:6] != 2'b01 || s_tdata[1:0] != 2'b00) err_c = ERR_HEADER;
                    else phase_next = PH_BD;
                end
                PH_BD: begin
                    fbi_next   = 4'd0;
                    phase_next = ((flags_reg & FLG_CSIZE) != 8'd0) ? PH_CSIZE : PH_HC;
                end
                PH_CSIZE: begin
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_reg == 4'd7) begin
                        fbi_next   = 4'd0;
                        phase_next = PH_HC;
                    end
                end
                PH_HC: begin
                    phase_next = PH_BSIZE;
                    fbi_next   = 4'd0;
                    bsize_next = 32'd0;
                end
                PH_BSIZE: begin
                    bsize_next = bsize_reg | ({24'd0, s_tdata} << {fbi_reg[1:0], 3'b000});
                    fbi_next   = fbi_reg + 4'd1;
                    if (fbi_reg[1:0] == 2'd3) begin
                        fbi_next   = 4'd0;
                        bcons_next = 32'd0;
                        if (bsize_next == 32'd0) begin
                            if ((flags_reg & FLG_FCHK) != 8'd0) phase_next = PH_FCHK;
                            else begin
                                fdone_next = fdone_reg + 16'd1;
                                if (fleft_reg == 16'd1) begin
                                    fleft_next  = 16'd0;
                                    sticky_next = ST_ENDED;
                                    ended_c     = 1'b1;
                                end else begin
                                    if (fleft_reg != 16'd0) fleft_next = fleft_reg - 16'd1;
                                    phase_next = PH_MAGIC;
                                    mok_next   = 1'b1;
                                end
                            end
                        end else if (bsize_next[31]) begin
                            bsize_next = {1'b0, bsize_next[30:0]};
                            if (bsize_next[30:0] == 31'd0) begin
                                phase_next = ((flags_reg & FLG_BCHK) != 8'd0) ? PH_BCHK
                                                                             : PH_BSIZE;
                                bsize_next = 32'd0;
                            end else phase_next = PH_STORED;
                        end else begin
                            phase_next = PH_TOKEN;
                        end
                    end
                end
                PH_STORED: begin
                    wr_en      = 1'b1;
                    kind_c     = KIND_DATA;
                    data_c     = s_tdata;
                    bcons_next = bcons_reg + 32'd1;
                    if (bcons_next >= bsize_reg) begin
                        blast_c = 1'b1;
                        if (!mode_reg) sticky_next = ST_ENDED;
                        else begin
                            phase_next = ((flags_reg & FLG_BCHK) != 8'd0) ? PH_BCHK : PH_BSIZE;
                            fbi_next   = 4'd0;
                            bsize_next = 32'd0;
                            bcons_next = 32'd0;
                        end
                    end
                end
                PH_BCHK: begin
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_reg == 4'd3) begin
                        fbi_next   = 4'd0;
                        bsize_next = 32'd0;
                        phase_next = PH_BSIZE;
                    end
                end
                PH_FCHK: begin
                    fbi_next = fbi_reg + 4'd1;
                    if (fbi_reg == 4'd3) begin
                        fbi_next   = 4'd0;
                        fdone_next = fdone_reg + 16'd1;
                        if (fleft_reg == 16'd1) begin
                            fleft_next  = 16'd0;
                            sticky_next = ST_ENDED;
                            ended_c     = 1'b1;
                        end else begin
                            if (fleft_reg != 16'd0) fleft_next = fleft_reg - 16'd1;
                            phase_next = PH_MAGIC;
                            mok_next   = 1'b1;
                        end
                    end
                end
                PH_TOKEN: begin
                    nib_next  = s_tdata[3:0];
                    lrem_next = {28'd0, s_tdata[7:4]};
                    if (s_tdata[7:4] == 4'd0) begin
                        if (bcons_next == bsize_reg) begin
                            if (!mode_reg) begin
                                sticky_next = ST_ENDED;
                                ended_c     = 1'b1;
                            end else begin
                                phase_next = ((flags_reg & FLG_BCHK) != 8'd0) ? PH_BCHK
                                                                             : PH_BSIZE;
                                fbi_next   = 4'd0;
                                bsize_next = 32'd0;
                                bcons_next = 32'd0;
                            end
                        end else phase_next = PH_OFFLO;
                    end else begin
                        phase_next = (s_tdata[7:4] == 4'hf) ? PH_LITLEN : PH_LITRUN;
                    end
                end
                PH_LITLEN: begin
                    sum33 = {1'b0, lrem_reg} + {25'd0, s_tdata};
                    if (sum33[32]) err_c = ERR_LENGTH;
                    else begin
                        lrem_next = sum33[31:0];
                        if (s_tdata != 8'hff) phase_next = PH_LITRUN;
                    end
                end
                PH_LITRUN: begin
                    wr_en     = 1'b1;
                    kind_c    = KIND_DATA;
                    data_c    = s_tdata;
                    lrem_next = lrem_reg - 32'd1;
                    if (lrem_reg == 32'd1) begin
                        if (bcons_next == bsize_reg) begin
                            blast_c = 1'b1;
                            if (!mode_reg) begin
                                sticky_next = ST_ENDED;
                                slast_c     = 1'b1;
                            end else begin
                                phase_next = ((flags_reg & FLG_BCHK) != 8'd0) ? PH_BCHK
                                                                             : PH_BSIZE;
                                fbi_next   = 4'd0;
                                bsize_next = 32'd0;
                                bcons_next = 32'd0;
                            end
                        end else phase_next = PH_OFFLO;
                    end
                end
                PH_OFFLO: begin
                    moff_next  = {8'd0, s_tdata};
                    phase_next = PH_OFFHI;
                end
                PH_OFFHI: begin
                    moff_next = {s_tdata, moff_reg[7:0]};
                    if (moff_next == 16'd0) err_c = ERR_OFFSET;
                    else if (nib_reg == 4'hf) begin
                        mrem_next  = 32'd15;
                        phase_next = PH_MATLEN;
                    end else begin
                        mrem_next  = {28'd0, nib_reg} + 32'd4;
                        phase_next = PH_TOKEN;
                    end
                end
                PH_MATLEN: begin
                    sum33 = {1'b0, mrem_reg} + {25'd0, s_tdata}
                            + ((s_tdata != 8'hff) ? 33'd4 : 33'd0);
                    if (sum33[32]) err_c = ERR_LENGTH;
                    else begin
                        mrem_next = sum33[31:0];
                        if (s_tdata != 8'hff) phase_next = PH_TOKEN;
                    end
                end
                default: err_c = ERR_HEADER;
            endcase
        end
        if (err_c != ST_RUN) begin
            sticky_next = err_c;
            mrem_next   = 32'd0;
            wr_en       = 1'b0;
        end
        if (sticky_next != ST_RUN && sticky_next != ST_ENDED) begin
            kind_c  = KIND_ERROR;
            data_c  = 8'd0;
            blast_c = 1'b0;
            slast_c = 1'b0;
        end else if (ended_c && kind_c != KIND_DATA) begin
            kind_c = KIND_ENDED;
        end
    end

    // window memory: clearing sweep, delayed byte writes, match source read
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            hist_mem[clr_pos_reg] <= 8'd0;
        end else if (pw_reg) begin
            hist_mem[pw_addr_reg] <= pw_data;
        end
        if (in_acc && tick_now) rd_data_reg <= hist_mem[src_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_pos_reg  <= '0;
            mode_reg     <= 1'b1;
            raw_bytes_reg <= 32'd0;
            flim_reg     <= 16'd0;
            wpos_reg     <= '0;
            phase_reg    <= PH_MAGIC;
            fbi_reg      <= 4'd0;
            moff_reg     <= 16'd0;
            mrem_reg     <= 32'd0;
            lrem_reg     <= 32'd0;
            bsize_reg    <= 32'd0;
            bcons_reg    <= 32'd0;
            flags_reg    <= 8'd0;
            fdone_reg    <= 16'd0;
            fleft_reg    <= 16'd0;
            mok_reg      <= 1'b1;
            sticky_reg   <= ST_RUN;
            nib_reg      <= 4'd0;
            ov_reg       <= 1'b0;
            otick_reg    <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_pos_reg <= clr_pos_reg + AW'(1);
                if (clr_pos_reg == AW'(WINDOW_BYTES - 1)) clearing_reg <= 1'b0;
            end
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            if (in_acc) begin
                ov_reg     <= 1'b1;
                phase_reg  <= phase_next;
                fbi_reg    <= fbi_next;
                moff_reg   <= moff_next;
                mrem_reg   <= mrem_next;
                lrem_reg   <= lrem_next;
                bsize_reg  <= bsize_next;
                bcons_reg  <= bcons_next;
                flags_reg  <= flags_next;
                fdone_reg  <= fdone_next;
                fleft_reg  <= fleft_next;
                mok_reg    <= mok_next;
                sticky_reg <= sticky_next;
                nib_reg    <= nib_next;
                otick_reg  <= tick_now;
                if (wr_en) wpos_reg <= wpos_reg + AW'(1);
            end
            if (cfg_acc) begin
                unique case (cfg_index)
                    REG_FRAME_MODE: mode_reg      <= cfg_data[0];
                    REG_RAW_BYTES:  raw_bytes_reg <= cfg_data;
                    REG_FRAME_LIM:  flim_reg      <= cfg_data[15:0];
                    default: ;
                endcase
                if (cfg_index == REG_FRAME_MODE || cfg_index == REG_RAW_BYTES
                    || cfg_index == REG_FRAME_LIM) begin
                    phase_reg  <= ((cfg_index == REG_FRAME_MODE) ? cfg_data[0] : mode_reg)
                                  ? PH_MAGIC : PH_TOKEN;
                    fbi_reg    <= 4'd0;
                    moff_reg   <= 16'd0;
                    mrem_reg   <= 32'd0;
                    lrem_reg   <= 32'd0;
                    bsize_reg  <= (cfg_index == REG_RAW_BYTES) ? cfg_data : raw_bytes_reg;
                    bcons_reg  <= 32'd0;
                    flags_reg  <= 8'd0;
                    fdone_reg  <= 16'd0;
                    fleft_reg  <= (cfg_index == REG_FRAME_LIM) ? cfg_data[15:0] : flim_reg;
                    mok_reg    <= 1'b1;
                    sticky_reg <= ST_RUN;
                    nib_reg    <= 4'd0;
                end
            end
        end
    end

    // pending write and tick byte path: a tick reading the entry written this edge forwards
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg      <= 1'b0;
            use_mem_reg <= 1'b1;
        end else begin
            pw_reg <= in_acc && wr_en;
            if (in_acc && tick_now) use_mem_reg <= !(pw_reg && pw_addr_reg == src_addr);
        end
        if (in_acc && wr_en) begin
            pw_addr_reg <= wpos_reg;
            pw_tick_reg <= tick_now;
            pw_byte_reg <= wr_byte;
        end
        if (in_acc && tick_now) fwd_reg <= pw_data;
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            okind_reg  <= kind_c;
            obyte_reg  <= data_c;
            oblast_reg <= blast_c;
            oslast_reg <= slast_c;
            ocp_reg    <= (sticky_next == ST_RUN) && (phase_next == PH_TOKEN)
                          && (mrem_next != 32'd0);
            oerr_reg   <= (kind_c == KIND_ERROR) ? sticky_next : ST_RUN;
        end else if (hold_reg == 1'b0 && otick_reg && ov_reg) begin
            obyte_reg <= tick_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) hold_reg <= 1'b0;
        else if (in_acc) hold_reg <= 1'b0;
        else if (ov_reg && otick_reg) hold_reg <= 1'b1;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {oerr_reg, ocp_reg, oslast_reg, oblast_reg,
                       (otick_reg && !hold_reg) ? tick_byte : obyte_reg, okind_reg};
endmodule

// ----- rtl/lz4fsd_checker.sv -----
// Port-level checks for the LZ4 frame stream decompressor.
module lz4fsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import lz4fsd_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != KIND_ERROR |-> m_tdata[15:13] == ST_RUN)
        else $error("error code without error kind");
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[1:0] == KIND_ERROR ##1 s_tvalid && s_tready
        |=> m_tdata[1:0] == KIND_ERROR || !m_tvalid)
        else $error("error not sticky");
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("request without result");
endmodule

bind lz4_frame_stream_decompressor lz4fsd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
